>>> src/dns_pkg.sv
// Shared types and character constants for the decimal numeral scanner.
`default_nettype none

package dns_pkg;

   localparam int CH_W      = 8;
   localparam int REQ_LEN_W = 13;
   localparam int POW_W     = 14;
   localparam int POW_MAX   = 8191;
   localparam int POW_MIN   = -8192;

   localparam logic signed [REQ_LEN_W-1:0] REQ_LEN_RESET = -13'sd1;

   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UP_E  = 8'h45;
   localparam logic [CH_W-1:0] CH_LOW_E = 8'h65;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_MANT,
      PH_EXP_START,
      PH_EXP_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_SIGN,
      ACT_MDIGIT,
      ACT_POINT,
      ACT_TO_EXP,
      ACT_TO_TRAIL,
      ACT_ESIGN,
      ACT_EDIGIT,
      ACT_END_OK,
      ACT_END_BAD
   } action_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            start_req;
   } scan_item_type;

endpackage

`default_nettype wire

>>> src/dns_if.sv
// Channel interfaces: byte input, scan result output and length register write.
`default_nettype none

interface dns_req_if;
   logic                      valid;
   logic                      ready;
   logic [dns_pkg::CH_W-1:0]  ch;
   logic                      start_req;

   modport source (output valid, output ch, output start_req, input ready);
   modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface dns_rsp_if #(
   parameter int MANTISSA_BITS = 64,
   parameter int LENGTH_BITS   = 12
);
   logic                             valid;
   logic                             ready;
   logic                             valid_res;
   logic                             negative;
   logic [MANTISSA_BITS-1:0]         mantissa;
   logic signed [dns_pkg::POW_W-1:0] power_of_ten;
   logic [LENGTH_BITS-1:0]           consumed;
   logic                             overflow;

   modport source (output valid, output valid_res, output negative, output mantissa,
                   output power_of_ten, output consumed, output overflow, input ready);
   modport sink   (input valid, input valid_res, input negative, input mantissa,
                   input power_of_ten, input consumed, input overflow, output ready);
endinterface

interface dns_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [dns_pkg::REQ_LEN_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/dns_in_stage.sv
// Input register: holds one accepted byte until the scan core takes it.
`default_nettype none

module dns_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   dns_req_if.sink                     req,
   input  wire logic                   take,
   output logic                        item_valid,
   output dns_pkg::scan_item_type      item
);

   logic                   valid_ff;
   logic                   valid_in;
   dns_pkg::scan_item_type item_ff;
   logic                   accept;

   assign req.ready  = !valid_ff || take;
   assign accept     = req.valid && req.ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.ch        <= req.ch;
         item_ff.start_req <= req.start_req;
      end
   end

endmodule

`default_nettype wire

>>> src/dns_scan_core.sv
// Scan FSM and datapath: one byte per cycle while out_free, mantissa*10 plus digit.
`default_nettype none

module dns_scan_core #(
   parameter int MANTISSA_BITS = 64,
   parameter int LENGTH_BITS   = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 item_valid,
   input  wire dns_pkg::scan_item_type               item,
   input  wire logic                                 out_free,
   input  wire logic signed [dns_pkg::REQ_LEN_W-1:0] required_length,
   output logic                                      take,
   output logic                                      res_valid,
   output logic                                      res_valid_res,
   output logic                                      res_negative,
   output logic [MANTISSA_BITS-1:0]                  res_mantissa,
   output logic signed [dns_pkg::POW_W-1:0]          res_power,
   output logic [LENGTH_BITS-1:0]                    res_consumed,
   output logic                                      res_overflow
);

   localparam int MW    = MANTISSA_BITS;
   localparam int LW    = LENGTH_BITS;
   localparam int P_W   = LW + 2;
   localparam int PX_W  = (P_W > dns_pkg::POW_W + 1) ? P_W : dns_pkg::POW_W + 1;
   localparam int CMP_W = (LW + 1 > dns_pkg::REQ_LEN_W) ? LW + 1 : dns_pkg::REQ_LEN_W;
   localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
   localparam logic signed [PX_W-1:0] P_HI = PX_W'(dns_pkg::POW_MAX);
   localparam logic signed [PX_W-1:0] P_LO = PX_W'(dns_pkg::POW_MIN);

   dns_pkg::phase_type  phase_ff, phase_in, cur_phase;
   dns_pkg::action_type act;

   logic [MW-1:0] mant_ff, mant_in, cur_mant;
   logic [LW-1:0] frac_ff, frac_in, cur_frac;
   logic [LW-1:0] exp_ff, exp_in, cur_exp;
   logic [LW-1:0] len_ff, len_in, cur_len, len_bump;
   logic          seen_point_ff, seen_point_in, cur_seen_point;
   logic          had_digit_ff, had_digit_in, cur_had_digit;
   logic          neg_ff, neg_in, cur_neg;
   logic          exp_neg_ff, exp_neg_in, cur_exp_neg;
   logic          exp_had_ff, exp_had_in, cur_exp_had;
   logic          sat_ff, sat_in, cur_sat;

   logic                        start;
   logic                        is_dig, is_pt, is_e, is_sp, is_minus, is_plus;
   logic [3:0]                  digit;
   logic [MW+3:0]               mant_prod;
   logic                        mant_ovf;
   logic [LW+3:0]               exp_prod;
   logic                        exp_ovf;
   logic signed [P_W-1:0]       e_val, p_val;
   logic signed [PX_W-1:0]      p_ext;
   logic signed [dns_pkg::POW_W-1:0] p_clamped;
   logic                        p_clip;
   logic signed [CMP_W-1:0]     len_x, req_x;
   logic                        ok;

   assign take  = item_valid && out_free;
   assign start = item.start_req;

   // Character classes
   assign is_dig   = (item.ch >= dns_pkg::CH_ZERO) && (item.ch <= dns_pkg::CH_NINE);
   assign is_pt    = (item.ch == dns_pkg::CH_POINT);
   assign is_e     = (item.ch == dns_pkg::CH_LOW_E) || (item.ch == dns_pkg::CH_UP_E);
   assign is_minus = (item.ch == dns_pkg::CH_MINUS);
   assign is_plus  = (item.ch == dns_pkg::CH_PLUS);
   assign is_sp    = item.ch[7] || ((item.ch != dns_pkg::CH_NUL) &&
                                    (item.ch <= dns_pkg::CH_SPACE));
   assign digit    = 4'(item.ch - dns_pkg::CH_ZERO);

   // A start byte scans against cleared state
   assign cur_phase      = start ? dns_pkg::PH_MANT : phase_ff;
   assign cur_mant       = start ? '0   : mant_ff;
   assign cur_frac       = start ? '0   : frac_ff;
   assign cur_exp        = start ? '0   : exp_ff;
   assign cur_len        = start ? '0   : len_ff;
   assign cur_seen_point = start ? 1'b0 : seen_point_ff;
   assign cur_had_digit  = start ? 1'b0 : had_digit_ff;
   assign cur_neg        = start ? 1'b0 : neg_ff;
   assign cur_exp_neg    = start ? 1'b0 : exp_neg_ff;
   assign cur_exp_had    = start ? 1'b0 : exp_had_ff;
   assign cur_sat        = start ? 1'b0 : sat_ff;

   assign len_bump = (cur_len == LEN_MAX) ? cur_len : cur_len + 1'b1;

   assign mant_prod = ({4'b0000, cur_mant} << 3) + ({4'b0000, cur_mant} << 1) +
                      (MW + 4)'(digit);
   assign mant_ovf  = |mant_prod[MW+3:MW];
   assign exp_prod  = ({4'b0000, cur_exp} << 3) + ({4'b0000, cur_exp} << 1) +
                      (LW + 4)'(digit);
   assign exp_ovf   = |exp_prod[LW+3:LW];

   // Decode the byte into one action
   always_comb begin
      act = dns_pkg::ACT_NONE;
      if (start && (is_minus || is_plus)) begin
         act = dns_pkg::ACT_SIGN;
      end else begin
         unique case (cur_phase)
            dns_pkg::PH_IDLE: begin
               act = dns_pkg::ACT_NONE;
            end
            dns_pkg::PH_MANT: begin
               priority if (is_dig) act = dns_pkg::ACT_MDIGIT;
               else if (is_pt)      act = cur_seen_point ? dns_pkg::ACT_END_OK
                                                         : dns_pkg::ACT_POINT;
               else if (!cur_had_digit) act = dns_pkg::ACT_END_BAD;
               else if (is_e)       act = dns_pkg::ACT_TO_EXP;
               else if (is_sp)      act = dns_pkg::ACT_TO_TRAIL;
               else                 act = dns_pkg::ACT_END_OK;
            end
            dns_pkg::PH_EXP_START, dns_pkg::PH_EXP_DIGITS: begin
               priority if ((cur_phase == dns_pkg::PH_EXP_START) && (is_minus || is_plus))
                  act = dns_pkg::ACT_ESIGN;
               else if (is_dig)        act = dns_pkg::ACT_EDIGIT;
               else if (is_pt || is_e) act = dns_pkg::ACT_END_BAD;
               else if (!cur_exp_had)  act = dns_pkg::ACT_END_BAD;
               else if (is_sp)         act = dns_pkg::ACT_TO_TRAIL;
               else                    act = dns_pkg::ACT_END_OK;
            end
            dns_pkg::PH_TRAIL: begin
               act = is_sp ? dns_pkg::ACT_TO_TRAIL : dns_pkg::ACT_END_OK;
            end
            default: begin
               act = dns_pkg::ACT_NONE;
            end
         endcase
      end
   end

   // Next phase
   always_comb begin
      unique case (act)
         dns_pkg::ACT_NONE:     phase_in = phase_ff;
         dns_pkg::ACT_SIGN,
         dns_pkg::ACT_MDIGIT,
         dns_pkg::ACT_POINT:    phase_in = dns_pkg::PH_MANT;
         dns_pkg::ACT_TO_EXP:   phase_in = dns_pkg::PH_EXP_START;
         dns_pkg::ACT_TO_TRAIL: phase_in = dns_pkg::PH_TRAIL;
         dns_pkg::ACT_ESIGN,
         dns_pkg::ACT_EDIGIT:   phase_in = dns_pkg::PH_EXP_DIGITS;
         dns_pkg::ACT_END_OK,
         dns_pkg::ACT_END_BAD:  phase_in = dns_pkg::PH_IDLE;
         default:               phase_in = phase_ff;
      endcase
   end

   // Scan datapath
   always_comb begin
      mant_in       = cur_mant;
      frac_in       = cur_frac;
      exp_in        = cur_exp;
      len_in        = cur_len;
      seen_point_in = cur_seen_point;
      had_digit_in  = cur_had_digit;
      neg_in        = cur_neg;
      exp_neg_in    = cur_exp_neg;
      exp_had_in    = cur_exp_had;
      sat_in        = cur_sat;
      unique case (act)
         dns_pkg::ACT_SIGN: begin
            neg_in = is_minus;
            len_in = len_bump;
         end
         dns_pkg::ACT_MDIGIT: begin
            mant_in      = mant_ovf ? {MW{1'b1}} : mant_prod[MW-1:0];
            had_digit_in = 1'b1;
            len_in       = len_bump;
            if (cur_seen_point) begin
               if (cur_frac == LEN_MAX) begin
                  sat_in = 1'b1;
               end else begin
                  frac_in = cur_frac + 1'b1;
               end
            end
            if (mant_ovf) begin
               sat_in = 1'b1;
            end
         end
         dns_pkg::ACT_POINT: begin
            seen_point_in = 1'b1;
            len_in        = len_bump;
         end
         dns_pkg::ACT_TO_EXP, dns_pkg::ACT_TO_TRAIL: begin
            len_in = len_bump;
         end
         dns_pkg::ACT_ESIGN: begin
            exp_neg_in = is_minus;
            len_in     = len_bump;
         end
         dns_pkg::ACT_EDIGIT: begin
            exp_in     = exp_ovf ? LEN_MAX : exp_prod[LW-1:0];
            exp_had_in = 1'b1;
            len_in     = len_bump;
            if (exp_ovf) begin
               sat_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result fields from the state the ending byte sees
   assign e_val = cur_exp_neg ? -$signed({2'b00, cur_exp}) : $signed({2'b00, cur_exp});
   assign p_val = e_val - $signed({2'b00, cur_frac});
   assign p_ext = PX_W'(p_val);

   always_comb begin
      priority if (p_ext > P_HI) begin
         p_clamped = dns_pkg::POW_W'(P_HI);
         p_clip    = 1'b1;
      end else if (p_ext < P_LO) begin
         p_clamped = dns_pkg::POW_W'(P_LO);
         p_clip    = 1'b1;
      end else begin
         p_clamped = dns_pkg::POW_W'(p_ext);
         p_clip    = 1'b0;
      end
   end

   assign len_x = CMP_W'($signed({1'b0, cur_len}));
   assign req_x = CMP_W'(required_length);
   assign ok    = (act == dns_pkg::ACT_END_OK) && cur_had_digit && !(len_x < req_x);

   assign res_valid     = take && ((act == dns_pkg::ACT_END_OK) ||
                                   (act == dns_pkg::ACT_END_BAD));
   assign res_valid_res = ok;
   assign res_negative  = ok && cur_neg;
   assign res_mantissa  = ok ? cur_mant : '0;
   assign res_power     = ok ? p_clamped : '0;
   assign res_consumed  = ok ? cur_len : '0;
   assign res_overflow  = ok && (cur_sat || p_clip);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= dns_pkg::PH_IDLE;
         mant_ff       <= '0;
         frac_ff       <= '0;
         exp_ff        <= '0;
         len_ff        <= '0;
         seen_point_ff <= 1'b0;
         had_digit_ff  <= 1'b0;
         neg_ff        <= 1'b0;
         exp_neg_ff    <= 1'b0;
         exp_had_ff    <= 1'b0;
         sat_ff        <= 1'b0;
      end else if (take) begin
         phase_ff      <= phase_in;
         mant_ff       <= mant_in;
         frac_ff       <= frac_in;
         exp_ff        <= exp_in;
         len_ff        <= len_in;
         seen_point_ff <= seen_point_in;
         had_digit_ff  <= had_digit_in;
         neg_ff        <= neg_in;
         exp_neg_ff    <= exp_neg_in;
         exp_had_ff    <= exp_had_in;
         sat_ff        <= sat_in;
      end
   end

   a_frac_needs_point: assert property (@(posedge clock) disable iff (reset)
      (frac_ff != '0) |-> seen_point_ff)
      else $error("fraction digits counted without a decimal point");

   a_mant_needs_digit: assert property (@(posedge clock) disable iff (reset)
      (mant_ff != '0) |-> had_digit_ff)
      else $error("mantissa nonzero without a mantissa digit");

   a_exp_needs_digit: assert property (@(posedge clock) disable iff (reset)
      (exp_ff != '0) |-> exp_had_ff)
      else $error("exponent nonzero without an exponent digit");

endmodule

`default_nettype wire

>>> src/dns_out_stage.sv
// Result register: holds one scan result until the consumer takes it.
`default_nettype none

module dns_out_stage #(
   parameter int MANTISSA_BITS = 64,
   parameter int LENGTH_BITS   = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   dns_rsp_if.source                                 rsp,
   input  wire logic                                 load,
   input  wire logic                                 valid_res,
   input  wire logic                                 negative,
   input  wire logic [MANTISSA_BITS-1:0]             mantissa,
   input  wire logic signed [dns_pkg::POW_W-1:0]     power_of_ten,
   input  wire logic [LENGTH_BITS-1:0]               consumed,
   input  wire logic                                 overflow,
   output logic                                      out_free
);

   logic                             valid_ff, valid_in;
   logic                             valid_res_ff;
   logic                             negative_ff;
   logic [MANTISSA_BITS-1:0]         mantissa_ff;
   logic signed [dns_pkg::POW_W-1:0] power_ff;
   logic [LENGTH_BITS-1:0]           consumed_ff;
   logic                             overflow_ff;

   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         valid_res_ff <= valid_res;
         negative_ff  <= negative;
         mantissa_ff  <= mantissa;
         power_ff     <= power_of_ten;
         consumed_ff  <= consumed;
         overflow_ff  <= overflow;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.valid_res    = valid_res_ff;
   assign rsp.negative     = negative_ff;
   assign rsp.mantissa     = mantissa_ff;
   assign rsp.power_of_ten = power_ff;
   assign rsp.consumed     = consumed_ff;
   assign rsp.overflow     = overflow_ff;

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !valid_res_ff) |->
         (mantissa_ff == '0 && consumed_ff == '0 && !overflow_ff && !negative_ff))
      else $error("invalid result item carries nonzero fields");

endmodule

`default_nettype wire

>>> src/decimal_numeral_scanner.sv
// Top level of the decimal numeral scanner.
// Scans one byte per req item and emits one rsp item when a numeral ends: sign, mantissa,
// power of ten, consumed length, overflow and a validity flag (fields are zero when
// invalid). A byte with start_req set begins a new string; bytes outside a string are
// dropped. Throughput is one byte per clock unless rsp stalls: the mantissa and exponent
// registers use a combinational multiply-by-ten-and-add, which bounds the clock. An
// accepted byte is held in the input register, scanned once the result register is free,
// and any result it ends is registered there before rsp shows it. The required length
// register is written through csr and must only change while no string is in flight.
`default_nettype none

module decimal_numeral_scanner #(
   parameter int MANTISSA_BITS = 64,
   parameter int LENGTH_BITS   = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   dns_req_if.sink   req_chan,
   dns_rsp_if.source rsp_chan,
   dns_csr_if.sink   csr_chan
);

   logic signed [dns_pkg::REQ_LEN_W-1:0] required_length_ff;
   logic signed [dns_pkg::REQ_LEN_W-1:0] required_length_in;

   logic                             take;
   logic                             item_valid;
   dns_pkg::scan_item_type           item;
   logic                             out_free;
   logic                             res_valid;
   logic                             res_valid_res;
   logic                             res_negative;
   logic [MANTISSA_BITS-1:0]         res_mantissa;
   logic signed [dns_pkg::POW_W-1:0] res_power;
   logic [LENGTH_BITS-1:0]           res_consumed;
   logic                             res_overflow;

   assign csr_chan.ready     = 1'b1;
   assign required_length_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data
                                                                   : required_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         required_length_ff <= dns_pkg::REQ_LEN_RESET;
      end else begin
         required_length_ff <= required_length_in;
      end
   end

   dns_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dns_scan_core #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_scan_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .out_free        (out_free),
      .required_length (required_length_ff),
      .take            (take),
      .res_valid       (res_valid),
      .res_valid_res   (res_valid_res),
      .res_negative    (res_negative),
      .res_mantissa    (res_mantissa),
      .res_power       (res_power),
      .res_consumed    (res_consumed),
      .res_overflow    (res_overflow)
   );

   dns_out_stage #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .rsp          (rsp_chan),
      .load         (res_valid),
      .valid_res    (res_valid_res),
      .negative     (res_negative),
      .mantissa     (res_mantissa),
      .power_of_ten (res_power),
      .consumed     (res_consumed),
      .overflow     (res_overflow),
      .out_free     (out_free)
   );

endmodule

`default_nettype wire

>>> bench/tb_decimal_numeral_scanner.sv
// Self-checking testbench for the decimal numeral scanner: byte stream in, scan results out.
module tb_decimal_numeral_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MANT_W = 64;
   localparam int LEN_W = 12;
   localparam logic [MANT_W-1:0] MANT_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam int CYCLE_LIMIT = 900_000;
   localparam int SETTLE_CYCLES = 6;
   localparam string NUMERAL_CHARS = "+-.eE0123456789 x";

   typedef struct packed {
      logic                             valid_res;
      logic                             negative;
      logic [MANT_W-1:0]                mantissa;
      logic signed [dns_pkg::POW_W-1:0] power_of_ten;
      logic [LEN_W-1:0]                 consumed;
      logic                             overflow;
   } numeral_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid_q = 1'b0;
   logic [dns_pkg::CH_W-1:0]             req_ch_q = '0;
   logic                                 req_start_q = 1'b0;
   logic                                 rsp_ready_q = 1'b0;
   logic                                 csr_valid_q = 1'b0;
   logic signed [dns_pkg::REQ_LEN_W-1:0] csr_data_q = '0;

   dns_req_if req_chan ();
   dns_rsp_if #(.MANTISSA_BITS(MANT_W), .LENGTH_BITS(LEN_W)) rsp_chan ();
   dns_csr_if csr_chan ();

   assign req_chan.valid     = req_valid_q;
   assign req_chan.ch        = req_ch_q;
   assign req_chan.start_req = req_start_q;
   assign rsp_chan.ready     = rsp_ready_q;
   assign csr_chan.valid     = csr_valid_q;
   assign csr_chan.data      = csr_data_q;

   decimal_numeral_scanner #(.MANTISSA_BITS(MANT_W), .LENGTH_BITS(LEN_W)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scanner state as the block should hold it
   dns_pkg::phase_type scan_phase;
   logic [MANT_W-1:0] acc_mantissa;
   logic [LEN_W-1:0]  acc_fraction;
   logic [LEN_W-1:0]  acc_exp;
   logic [LEN_W-1:0]  byte_count;
   logic point_seen, digit_seen, minus_seen, exp_minus, exp_digit_seen, sat_seen;
   int min_length;

   dns_pkg::scan_item_type bytes_to_send[$];
   numeral_type            expected_numerals[$];
   numeral_type            predicted, want;
   dns_pkg::scan_item_type next_byte;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int bytes_accepted = 0;
   int results_checked = 0;
   int valid_results = 0;
   int settings_used = 1;
   int made = 0;
   logic next_start = 1'b0;

   function automatic void clear_scan();
      scan_phase = dns_pkg::PH_IDLE;
      acc_mantissa = '0;
      acc_fraction = '0;
      acc_exp = '0;
      byte_count = '0;
      point_seen = 1'b0;
      digit_seen = 1'b0;
      minus_seen = 1'b0;
      exp_minus = 1'b0;
      exp_digit_seen = 1'b0;
      sat_seen = 1'b0;
   endfunction

   function automatic void bump_count();
      if (byte_count < LEN_MAX) byte_count++;
   endfunction

   function automatic bit is_digit(input logic [dns_pkg::CH_W-1:0] c);
      return c >= dns_pkg::CH_ZERO && c <= dns_pkg::CH_NINE;
   endfunction

   function automatic bit is_space(input logic [dns_pkg::CH_W-1:0] c);
      return c != dns_pkg::CH_NUL && (c <= dns_pkg::CH_SPACE || c >= 8'h80);
   endfunction

   function automatic numeral_type close_numeral(input bit well_formed);
      numeral_type r;
      int e;
      int p;
      bit ok;
      r = '0;
      ok = well_formed && digit_seen;
      if (ok && min_length >= 0 && int'(byte_count) < min_length) ok = 1'b0;
      if (ok) begin
         e = exp_minus ? -int'(acc_exp) : int'(acc_exp);
         p = e - int'(acc_fraction);
         r.overflow = sat_seen;
         if (p > dns_pkg::POW_MAX) begin
            p = dns_pkg::POW_MAX;
            r.overflow = 1'b1;
         end
         if (p < dns_pkg::POW_MIN) begin
            p = dns_pkg::POW_MIN;
            r.overflow = 1'b1;
         end
         r.valid_res = 1'b1;
         r.negative = minus_seen;
         r.mantissa = acc_mantissa;
         r.power_of_ten = dns_pkg::POW_W'(p);
         r.consumed = byte_count;
      end
      scan_phase = dns_pkg::PH_IDLE;
      return r;
   endfunction

   // Advance the scan by one byte; return 1 when the byte ends a numeral
   function automatic bit scan_byte(input logic [dns_pkg::CH_W-1:0] c, input bit start,
                                    output numeral_type r);
      logic [MANT_W-1:0] d64;
      logic [LEN_W-1:0]  d12;
      r = '0;
      d64 = MANT_W'(c - dns_pkg::CH_ZERO);
      d12 = LEN_W'(c - dns_pkg::CH_ZERO);
      if (start) begin
         clear_scan();
         scan_phase = dns_pkg::PH_MANT;
         if (c == dns_pkg::CH_MINUS) begin
            minus_seen = 1'b1;
            bump_count();
            return 1'b0;
         end
         if (c == dns_pkg::CH_PLUS) begin
            bump_count();
            return 1'b0;
         end
      end else if (scan_phase == dns_pkg::PH_IDLE) begin
         return 1'b0;
      end
      if (scan_phase == dns_pkg::PH_EXP_START) begin
         if (c == dns_pkg::CH_MINUS || c == dns_pkg::CH_PLUS) begin
            exp_minus = (c == dns_pkg::CH_MINUS);
            bump_count();
            scan_phase = dns_pkg::PH_EXP_DIGITS;
            return 1'b0;
         end
         scan_phase = dns_pkg::PH_EXP_DIGITS;
      end
      case (scan_phase)
         dns_pkg::PH_MANT: begin
            if (is_digit(c)) begin
               if (acc_mantissa > (MANT_MAX - d64) / 10) begin
                  acc_mantissa = MANT_MAX;
                  sat_seen = 1'b1;
               end else begin
                  acc_mantissa = acc_mantissa * 10 + d64;
               end
               digit_seen = 1'b1;
               if (point_seen) begin
                  if (acc_fraction < LEN_MAX) acc_fraction++;
                  else sat_seen = 1'b1;
               end
               bump_count();
               return 1'b0;
            end
            if (c == dns_pkg::CH_POINT) begin
               // a second point ends the numeral without consuming it
               if (point_seen) begin
                  r = close_numeral(1'b1);
                  return 1'b1;
               end
               point_seen = 1'b1;
               bump_count();
               return 1'b0;
            end
            if (!digit_seen) begin
               r = close_numeral(1'b0);
               return 1'b1;
            end
            if (c == dns_pkg::CH_LOW_E || c == dns_pkg::CH_UP_E) begin
               bump_count();
               scan_phase = dns_pkg::PH_EXP_START;
               return 1'b0;
            end
            if (is_space(c)) begin
               bump_count();
               scan_phase = dns_pkg::PH_TRAIL;
               return 1'b0;
            end
            r = close_numeral(1'b1);
            return 1'b1;
         end
         dns_pkg::PH_EXP_DIGITS: begin
            if (is_digit(c)) begin
               if (acc_exp > (LEN_MAX - d12) / 10) begin
                  acc_exp = LEN_MAX;
                  sat_seen = 1'b1;
               end else begin
                  acc_exp = LEN_W'(acc_exp * 10 + d12);
               end
               exp_digit_seen = 1'b1;
               bump_count();
               return 1'b0;
            end
            if (c == dns_pkg::CH_POINT || c == dns_pkg::CH_LOW_E || c == dns_pkg::CH_UP_E ||
                !exp_digit_seen) begin
               r = close_numeral(1'b0);
               return 1'b1;
            end
            if (is_space(c)) begin
               bump_count();
               scan_phase = dns_pkg::PH_TRAIL;
               return 1'b0;
            end
            r = close_numeral(1'b1);
            return 1'b1;
         end
         default: begin
            if (is_space(c)) begin
               bump_count();
               return 1'b0;
            end
            r = close_numeral(1'b1);
            return 1'b1;
         end
      endcase
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int idle_span(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] exp_val,
                                       input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      end
   endfunction

   // Driver: hold the item until taken, then advance after a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
      end else if (!req_valid_q || req_fire) begin
         if (gap_left > 0) begin
            req_valid_q <= 1'b0;
            gap_left--;
         end else if (bytes_to_send.size() != 0) begin
            next_byte = bytes_to_send.pop_front();
            req_valid_q <= 1'b1;
            req_ch_q <= next_byte.ch;
            req_start_q <= next_byte.start_req;
            gap_left = idle_span(req_calm);
         end else begin
            req_valid_q <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready_q <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready_q <= 1'b1;
         if (rsp_fire || $urandom_range(0, 7) == 0) stall_left = idle_span(rsp_calm);
      end
   end

   // Monitor: predict on each accepted byte, check each accepted result
   always @(posedge clock) begin
      req_fire <= req_chan.valid && req_chan.ready;
      rsp_fire <= rsp_chan.valid && rsp_chan.ready;
      cycle_count++;
      if (reset) begin
         clear_scan();
         min_length = int'(dns_pkg::REQ_LEN_RESET);
      end else begin
         if (csr_chan.valid && csr_chan.ready) min_length = int'(csr_chan.data);
         if (req_chan.valid && req_chan.ready) begin
            bytes_accepted++;
            if (scan_byte(req_chan.ch, req_chan.start_req, predicted))
               expected_numerals.push_back(predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_numerals.size() == 0) begin
               mismatches++;
               $display("%0t: result expected none actual valid_res %0b mantissa %0h",
                        $time, rsp_chan.valid_res, rsp_chan.mantissa);
            end else begin
               want = expected_numerals.pop_front();
               results_checked++;
               if (want.valid_res) valid_results++;
               check_field("valid_res", want.valid_res, rsp_chan.valid_res);
               check_field("negative", want.negative, rsp_chan.negative);
               check_field("mantissa", want.mantissa, rsp_chan.mantissa);
               check_field("power_of_ten", want.power_of_ten, rsp_chan.power_of_ten);
               check_field("consumed", want.consumed, rsp_chan.consumed);
               check_field("overflow", want.overflow, rsp_chan.overflow);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_numerals.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic void put(input logic [dns_pkg::CH_W-1:0] c);
      bytes_to_send.push_back('{ch: c, start_req: next_start});
      next_start = 1'b0;
      made++;
   endfunction

   function automatic void start_text(input string s);
      next_start = 1'b1;
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic logic [dns_pkg::CH_W-1:0] rand_digit();
      return dns_pkg::CH_ZERO + dns_pkg::CH_W'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed numerals with random content, the rest broken strings
   function automatic void add_numeral();
      int k;
      int span;
      next_start = 1'b1;
      if ($urandom_range(0, 99) < 80) begin
         k = $urandom_range(0, 3);
         if (k == 0) put(dns_pkg::CH_MINUS);
         else if (k == 1) put(dns_pkg::CH_PLUS);
         span = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 5);
         repeat (span) put(rand_digit());
         if ($urandom_range(0, 1)) begin
            put(dns_pkg::CH_POINT);
            repeat ($urandom_range(0, 4)) put(rand_digit());
         end
         if ($urandom_range(0, 2) == 0) begin
            put($urandom_range(0, 1) ? dns_pkg::CH_LOW_E : dns_pkg::CH_UP_E);
            k = $urandom_range(0, 2);
            if (k == 0) put(dns_pkg::CH_MINUS);
            else if (k == 1) put(dns_pkg::CH_PLUS);
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3);
            repeat (span) put(rand_digit());
         end
         repeat ($urandom_range(0, 3))
            put($urandom_range(0, 1) ? dns_pkg::CH_W'($urandom_range(1, 32))
                                     : dns_pkg::CH_W'($urandom_range(128, 255)));
         // end with NUL, some other byte, or nothing so the next start cuts in
         k = $urandom_range(0, 9);
         if (k < 5) put(dns_pkg::CH_NUL);
         else if (k < 8) put(dns_pkg::CH_W'($urandom_range(33, 127)));
      end else begin
         repeat ($urandom_range(1, 8))
            put($urandom_range(0, 1) ? dns_pkg::CH_W'($urandom_range(0, 255))
                  : NUMERAL_CHARS[$urandom_range(0, NUMERAL_CHARS.len() - 1)]);
      end
      // stray bytes with no start
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            bytes_to_send.push_back('{ch: dns_pkg::CH_W'($urandom_range(0, 255)),
                                      start_req: 1'b0});
   endfunction

   task automatic settle();
      int waited;
      waited = 0;
      while (bytes_to_send.size() != 0 || req_valid_q) @(posedge clock);
      while (expected_numerals.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_numerals.size() != 0) begin
         mismatches += expected_numerals.size();
         $display("%0t: %0d results expected actual none, next mantissa %0h consumed %0d",
                  $time, expected_numerals.size(), expected_numerals[0].mantissa,
                  expected_numerals[0].consumed);
         expected_numerals.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_min_length(input int value);
      @(negedge clock);
      csr_valid_q <= 1'b1;
      csr_data_q <= dns_pkg::REQ_LEN_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_valid_q <= 1'b0;
      settings_used++;
   endtask

   task automatic random_phase(input int count);
      made = 0;
      while (made < count) add_numeral();
      // drop the block back to idle before the next register write
      next_start = 1'b0;
      put(dns_pkg::CH_NUL);
      settle();
   endtask

   int length_settings[5] = '{0, 5, -1, 12, 3};

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start_text("-9.5e+12 ");
      put(dns_pkg::CH_NUL);
      start_text("+.25E-3\t7");
      start_text("1.2.5");
      start_text("-");
      put(dns_pkg::CH_NUL);
      start_text(".e5");
      put(dns_pkg::CH_NUL);
      start_text("5e");
      put(dns_pkg::CH_NUL);
      start_text("5e2.3");
      start_text("5E-2e");
      start_text("12");
      start_text("34 ");
      put(8'hFF);
      put(8'h80);
      put(8'h01);
      put(dns_pkg::CH_NUL);
      start_text("9999999999999999999999999");
      put(dns_pkg::CH_NUL);
      start_text("18446744073709551615");
      put(dns_pkg::CH_NUL);
      start_text("1e99999");
      put(dns_pkg::CH_NUL);
      start_text("7x");
      start_text("e5");
      put(dns_pkg::CH_NUL);
      start_text("0");
      put(dns_pkg::CH_NUL);
      settle();

      foreach (length_settings[i]) begin
         set_min_length(length_settings[i]);
         random_phase(100);
      end

      // longest length rule: every numeral falls short of it
      set_min_length(int'(LEN_MAX));
      random_phase(50);

      $display("%0d bytes scanned over %0d length settings", bytes_accepted, settings_used);
      $display("%0d results checked, %0d of them valid numerals", results_checked,
               valid_results);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
src/dns_pkg.sv
src/dns_if.sv
src/dns_in_stage.sv
src/dns_scan_core.sv
src/dns_out_stage.sv
src/decimal_numeral_scanner.sv
bench/tb_decimal_numeral_scanner.sv
